### design/gfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_pkg
// Shared constants for the Goldilocks field ALU (p = 2^64 - 2^32 + 1).
// ----------------------------------------------------------------------------
package gfa_pkg;

  localparam int WORD_W = 64;
  localparam int OP_W   = 2;

  localparam logic [WORD_W-1:0] PRIME = 64'hFFFF_FFFF_0000_0001;
  localparam logic [WORD_W-1:0] EPS   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [WORD_W-1:0] ONE   = 64'd1;

  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_MUL  = 2'd1;
  localparam logic [OP_W-1:0] OP_POW7 = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // fold stage plus four multiplier units of four stages each
  localparam int MUL_STAGES = 4;
  localparam int MUL_UNITS  = 4;
  localparam int PIPE_DEPTH = 1 + MUL_UNITS * MUL_STAGES;

endpackage

`default_nettype wire

### design/gfa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_req_if
// Request channel: operation code and two field operands.
// ----------------------------------------------------------------------------
interface gfa_req_if;

  logic                       valid;
  logic                       ready;
  logic [gfa_pkg::OP_W-1:0]   req_type;
  logic [gfa_pkg::WORD_W-1:0] operand_a;
  logic [gfa_pkg::WORD_W-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input req_type, input operand_a, input operand_b,
                  output ready);

endinterface

`default_nettype wire

### design/gfa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_rsp_if
// Response channel: canonical field result.
// ----------------------------------------------------------------------------
interface gfa_rsp_if;

  logic                       valid;
  logic                       ready;
  logic [gfa_pkg::WORD_W-1:0] field_result;

  modport source (output valid, output field_result, input ready);
  modport sink   (input valid, input field_result, output ready);

endinterface

`default_nettype wire

### design/gfa_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_fold
// Entry stage: registers the request and forms the modular sum, folding a
// carry out of bit 63 back in as 2^32 - 1.
// ----------------------------------------------------------------------------
module gfa_fold (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [gfa_pkg::OP_W-1:0]   op_in,
  input  wire logic [gfa_pkg::WORD_W-1:0] a_in,
  input  wire logic [gfa_pkg::WORD_W-1:0] b_in,
  output logic      [gfa_pkg::OP_W-1:0]   op,
  output logic      [gfa_pkg::WORD_W-1:0] a,
  output logic      [gfa_pkg::WORD_W-1:0] b,
  output logic      [gfa_pkg::WORD_W-1:0] sum
);

  logic [gfa_pkg::WORD_W:0]   s;
  logic [gfa_pkg::WORD_W:0]   t;
  logic [gfa_pkg::WORD_W-1:0] sum_next;

  always_comb begin
    s = {1'b0, a_in} + {1'b0, b_in};
    t = {1'b0, s[gfa_pkg::WORD_W-1:0]} + {1'b0, gfa_pkg::EPS};
    if (!s[gfa_pkg::WORD_W]) begin
      sum_next = s[gfa_pkg::WORD_W-1:0];
    end else if (t[gfa_pkg::WORD_W]) begin
      sum_next = t[gfa_pkg::WORD_W-1:0] + gfa_pkg::EPS;
    end else begin
      sum_next = t[gfa_pkg::WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op  <= op_in;
      a   <= a_in;
      b   <= b_in;
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

### design/gfa_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfa_mul
// Four-stage field multiplier: 32x32 partial products, 128-bit assembly,
// reduction with 2^64 = 2^32 - 1 and 2^96 = -1, then canonical form.
// A side word travels alongside with the same delay.
// ----------------------------------------------------------------------------
module gfa_mul #(
  parameter int SIDE_W = 2
) (
  input  wire logic                                 clk,
  input  wire logic [gfa_pkg::MUL_STAGES-1:0]       en,
  input  wire logic [gfa_pkg::WORD_W-1:0]           x,
  input  wire logic [gfa_pkg::WORD_W-1:0]           y,
  input  wire logic [SIDE_W-1:0]                    side_in,
  output logic      [gfa_pkg::WORD_W-1:0]           prod,
  output logic      [SIDE_W-1:0]                    side_out
);

  localparam int W  = gfa_pkg::WORD_W;
  localparam int HW = W / 2;

  logic [SIDE_W-1:0] side [gfa_pkg::MUL_STAGES-1];

  // stage 1
  logic [W-1:0] pp_ll, pp_lh, pp_hl, pp_hh;
  // stage 2
  logic [W:0]     cross_sum;
  logic [2*W-1:0] full_next;
  logic [W-1:0]   lo, hi;
  // stage 3
  logic [W:0]     diff;
  logic [W-1:0]   t0_next, t1_next;
  logic [W-1:0]   t0, t1;
  // stage 4
  logic [W:0]     s;
  logic [W-1:0]   t2;
  logic [W-1:0]   prod_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp_ll   <= W'(x[HW-1:0] * y[HW-1:0]);
      pp_lh   <= W'(x[HW-1:0] * y[W-1:HW]);
      pp_hl   <= W'(x[W-1:HW] * y[HW-1:0]);
      pp_hh   <= W'(x[W-1:HW] * y[W-1:HW]);
      side[0] <= side_in;
    end
  end

  always_comb begin
    cross_sum = {1'b0, pp_lh} + {1'b0, pp_hl};
    full_next = {pp_hh, pp_ll} + {{(HW-1){1'b0}}, cross_sum, {HW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lo      <= full_next[W-1:0];
      hi      <= full_next[2*W-1:W];
      side[1] <= side[0];
    end
  end

  always_comb begin
    diff    = {1'b0, lo} - {{(HW+1){1'b0}}, hi[W-1:HW]};
    t0_next = diff[W] ? (diff[W-1:0] - gfa_pkg::EPS) : diff[W-1:0];
    t1_next = {hi[HW-1:0], {HW{1'b0}}} - {{HW{1'b0}}, hi[HW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t0      <= t0_next;
      t1      <= t1_next;
      side[2] <= side[1];
    end
  end

  always_comb begin
    s         = {1'b0, t0} + {1'b0, t1};
    t2        = s[W] ? (s[W-1:0] + gfa_pkg::EPS) : s[W-1:0];
    prod_next = (t2 >= gfa_pkg::PRIME) ? (t2 - gfa_pkg::PRIME) : t2;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      prod     <= prod_next;
      side_out <= side[2];
    end
  end

endmodule

`default_nettype wire

### design/goldilocks_field_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// goldilocks_field_alu
// Add, multiply and x^7 over the field p = 2^64 - 2^32 + 1, fully pipelined.
//
// Requests arrive on req (req_type, operand_a, operand_b); results leave on
// rsp (field_result), one per request, in request order. Operands may be any
// 64-bit value; results are always canonical. req_type 3 returns zero.
// Every item runs a fold stage and four chained multiplier units (four
// stages each), 17 registers in all, and a new request is taken every
// cycle unless a stalled rsp has filled every stage. Add and multiply
// ride the chain multiplied by one; x^7 uses all four units (x2, x4, x6, x7).
// Each stage holds its own valid bit; a stage loads when it is empty or the
// stage after it moves, so bubbles collapse while rsp is stalled and req.ready
// drops only once every stage is full. Reset (rst, synchronous) empties all
// stages; nothing is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module goldilocks_field_alu (
  input  wire logic clk,
  input  wire logic rst,
  gfa_req_if.sink   req,
  gfa_rsp_if.source rsp
);

  localparam int W  = gfa_pkg::WORD_W;
  localparam int OW = gfa_pkg::OP_W;
  localparam int MS = gfa_pkg::MUL_STAGES;
  localparam int D  = gfa_pkg::PIPE_DEPTH;

  logic [D-1:0] valid;
  logic [D-1:0] en;

  always_comb begin
    en[D-1] = !valid[D-1] || rsp.ready;
    for (int i = D - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= req.valid;
      end
      for (int i = 1; i < D; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign req.ready = en[0];
  assign rsp.valid = valid[D-1];

  // fold stage
  logic [OW-1:0] f_op;
  logic [W-1:0]  f_a, f_b, f_sum;

  gfa_fold u_fold (
    .clk   (clk),
    .en    (en[0]),
    .op_in (req.req_type),
    .a_in  (req.operand_a),
    .b_in  (req.operand_b),
    .op    (f_op),
    .a     (f_a),
    .b     (f_b),
    .sum   (f_sum)
  );

  // unit 1: x*x, a*b, or sum*1
  logic [W-1:0]    m1_x, m1_y, m1;
  logic [OW+W-1:0] s1;

  always_comb begin
    case (f_op)
      gfa_pkg::OP_ADD: begin
        m1_x = f_sum;
        m1_y = gfa_pkg::ONE;
      end
      gfa_pkg::OP_MUL: begin
        m1_x = f_a;
        m1_y = f_b;
      end
      gfa_pkg::OP_POW7: begin
        m1_x = f_a;
        m1_y = f_a;
      end
      default: begin
        m1_x = '0;
        m1_y = '0;
      end
    endcase
  end

  gfa_mul #(.SIDE_W(OW + W)) u_mul1 (
    .clk      (clk),
    .en       (en[1 +: MS]),
    .x        (m1_x),
    .y        (m1_y),
    .side_in  ({f_op, f_a}),
    .prod     (m1),
    .side_out (s1)
  );

  // unit 2: x4 = x2*x2
  logic [W-1:0]      m2_y, m2;
  logic [OW+2*W-1:0] s2;

  assign m2_y = (s1[OW+W-1:W] == gfa_pkg::OP_POW7) ? m1 : gfa_pkg::ONE;

  gfa_mul #(.SIDE_W(OW + 2 * W)) u_mul2 (
    .clk      (clk),
    .en       (en[1+MS +: MS]),
    .x        (m1),
    .y        (m2_y),
    .side_in  ({s1, m1}),
    .prod     (m2),
    .side_out (s2)
  );

  // unit 3: x6 = x4*x2
  logic [W-1:0]    m3_y, m3;
  logic [OW+W-1:0] s3;

  assign m3_y = (s2[OW+2*W-1:2*W] == gfa_pkg::OP_POW7) ? s2[W-1:0] : gfa_pkg::ONE;

  gfa_mul #(.SIDE_W(OW + W)) u_mul3 (
    .clk      (clk),
    .en       (en[1+2*MS +: MS]),
    .x        (m2),
    .y        (m3_y),
    .side_in  (s2[OW+2*W-1:W]),
    .prod     (m3),
    .side_out (s3)
  );

  // unit 4: x7 = x6*x
  logic [W-1:0]  m4_y, m4;
  logic [OW-1:0] s4;

  assign m4_y = (s3[OW+W-1:W] == gfa_pkg::OP_POW7) ? s3[W-1:0] : gfa_pkg::ONE;

  gfa_mul #(.SIDE_W(OW)) u_mul4 (
    .clk      (clk),
    .en       (en[1+3*MS +: MS]),
    .x        (m3),
    .y        (m4_y),
    .side_in  (s3[OW+W-1:W]),
    .prod     (m4),
    .side_out (s4)
  );

  assign rsp.field_result = (s4 == gfa_pkg::OP_NONE) ? '0 : m4;

endmodule

`default_nettype wire
